// ===== rtl/core/dmsc_pkg.sv =====
// Package for the date month shift and compare block.
// Holds the item types of both channels and the divide-by-constant factors.
// No dependencies.
package dmsc_pkg;

   // Field widths of the date items.
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned DELTA_W = 12;

   // Largest year a shifted date may land on.
   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   // Operation codes for the shift direction.
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   // floor(x / 12) = (x * 2731) >> 15, exact for every 12-bit x.
   localparam logic [11:0] DIV12_MUL   = 12'd2731;
   localparam int unsigned DIV12_SHIFT = 15;

   // floor(y / 100) = (y * 5243) >> 19, exact for every year up to 9999.
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;

   // One input item.
   typedef struct packed {
      logic               op;
      logic [MONTH_W-1:0] month_in;
      logic [DAY_W-1:0]   day_in;
      logic [YEAR_W-1:0]  year_in;
      logic [DELTA_W-1:0] month_delta;
      logic [MONTH_W-1:0] other_month;
      logic [DAY_W-1:0]   other_day;
      logic [YEAR_W-1:0]  other_year;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [MONTH_W-1:0] month_out;
      logic [DAY_W-1:0]   day_out;
      logic [YEAR_W-1:0]  year_out;
      logic               out_of_range;
      logic               is_before;
      logic               is_after;
      logic               is_same;
   } rsp_type;

endpackage

// ===== rtl/core/date_month_shift_and_compare.sv =====
// Date month shift and compare top level, a three-stage pipeline; needs dmsc_pkg.
// A result appears on rsp_strobe once the item has passed the input, middle and result registers.
// Throughput: one item per cycle; busy is never raised and the receiver cannot stall.
// Stage one registers the item, stage two does the month shift with a divide by 12,
// and stage three does the leap-year test with a divide by 100 and clamps the day.
// Reset clears the pipeline valid flags; payload registers are not reset.
module date_month_shift_and_compare (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dmsc_pkg::req_type req_item,
   output logic              rsp_strobe,
   output dmsc_pkg::rsp_type rsp_item
);

   // Shifted date before the leap-year test, plus what the result stage needs.
   typedef struct packed {
      logic [dmsc_pkg::MONTH_W-1:0] month_new;
      logic [dmsc_pkg::YEAR_W-1:0]  year_new;
      logic                         out_of_range;
      logic [dmsc_pkg::MONTH_W-1:0] month_orig;
      logic [dmsc_pkg::DAY_W-1:0]   day_orig;
      logic [dmsc_pkg::YEAR_W-1:0]  year_orig;
      logic                         is_before;
      logic                         is_after;
      logic                         is_same;
   } mid_type;

   logic              in_valid_ff;
   dmsc_pkg::req_type in_item_ff;
   logic              mid_valid_ff;
   mid_type           mid_ff;
   mid_type           mid_in;
   logic              rsp_valid_ff;
   dmsc_pkg::rsp_type rsp_ff;
   dmsc_pkg::rsp_type rsp_in;

   // Stage two signals.
   logic [23:0]        div12_prod;
   logic [8:0]         delta_years;
   logic [11:0]        delta_years_x12;
   logic [3:0]         delta_months;
   logic signed [5:0]  month_sum;
   logic signed [1:0]  year_carry;
   logic signed [5:0]  month_norm;
   logic signed [15:0] year_delta;
   logic signed [15:0] year_sum;

   // Stage three signals.
   logic [26:0] div100_prod;
   logic [7:0]  century;
   logic [13:0] century_x100;
   logic        div_by_4;
   logic        div_by_100;
   logic        div_by_400;
   logic        leap;
   logic [4:0]  month_len;

   // Every item can be taken in every cycle.
   assign busy = 1'b0;

   // Stage two: split the delta into years and months, then add or subtract.
   always_comb begin
      div12_prod      = 24'(in_item_ff.month_delta) * 24'(dmsc_pkg::DIV12_MUL);
      delta_years     = div12_prod[dmsc_pkg::DIV12_SHIFT +: 9];
      delta_years_x12 = 12'({delta_years, 3'b000}) + 12'({delta_years, 2'b00});
      delta_months    = 4'(in_item_ff.month_delta - delta_years_x12);

      // Zero-based month plus or minus the leftover months, range -12..25.
      if (in_item_ff.op == dmsc_pkg::OP_SUB) begin
         month_sum  = $signed({2'b00, in_item_ff.month_in}) - 6'sd1
                      - $signed({2'b00, delta_months});
         year_delta = -$signed({7'b0000000, delta_years});
      end else begin
         month_sum  = $signed({2'b00, in_item_ff.month_in}) - 6'sd1
                      + $signed({2'b00, delta_months});
         year_delta = $signed({7'b0000000, delta_years});
      end

      // Bring the month back into 0..11 and carry into the year.
      if (month_sum < 6'sd0) begin
         year_carry = -2'sd1;
         month_norm = month_sum + 6'sd12;
      end else if (month_sum < 6'sd12) begin
         year_carry = 2'sd0;
         month_norm = month_sum;
      end else if (month_sum < 6'sd24) begin
         year_carry = 2'sd1;
         month_norm = month_sum - 6'sd12;
      end else begin
         year_carry = 2'sd1;
         month_norm = month_sum - 6'sd24;
      end

      year_sum = $signed({2'b00, in_item_ff.year_in}) + year_delta
                 + $signed({{14{year_carry[1]}}, year_carry});
      if (month_sum >= 6'sd24) begin
         year_sum = year_sum + 16'sd1;
      end

      mid_in.month_new    = 4'(month_norm) + 4'd1;
      mid_in.year_new     = year_sum[dmsc_pkg::YEAR_W-1:0];
      mid_in.out_of_range = year_sum[15] ||
                            (year_sum > $signed({2'b00, dmsc_pkg::YEAR_MAX}));
      mid_in.month_orig   = in_item_ff.month_in;
      mid_in.day_orig     = in_item_ff.day_in;
      mid_in.year_orig    = in_item_ff.year_in;

      // Raw fields compared year first, then month, then day.
      mid_in.is_before = {in_item_ff.year_in, in_item_ff.month_in, in_item_ff.day_in} <
                         {in_item_ff.other_year, in_item_ff.other_month,
                          in_item_ff.other_day};
      mid_in.is_after  = {in_item_ff.year_in, in_item_ff.month_in, in_item_ff.day_in} >
                         {in_item_ff.other_year, in_item_ff.other_month,
                          in_item_ff.other_day};
      mid_in.is_same   = {in_item_ff.year_in, in_item_ff.month_in, in_item_ff.day_in} ==
                         {in_item_ff.other_year, in_item_ff.other_month,
                          in_item_ff.other_day};
   end

   // Stage three: full Gregorian leap-year rule, month length and day clamp.
   always_comb begin
      div100_prod  = 27'(mid_ff.year_new) * 27'(dmsc_pkg::DIV100_MUL);
      century      = div100_prod[dmsc_pkg::DIV100_SHIFT +: 8];
      century_x100 = 14'({century, 6'b000000}) + 14'({century, 5'b00000})
                     + 14'({century, 2'b00});
      div_by_4     = (mid_ff.year_new[1:0] == 2'b00);
      div_by_100   = (mid_ff.year_new == century_x100);
      div_by_400   = div_by_100 && (century[1:0] == 2'b00);
      leap         = div_by_4 && (!div_by_100 || div_by_400);

      case (mid_ff.month_new) inside
         4'd2:                      month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
         default:                   month_len = 5'd31;
      endcase

      rsp_in.out_of_range = mid_ff.out_of_range;
      rsp_in.is_before    = mid_ff.is_before;
      rsp_in.is_after     = mid_ff.is_after;
      rsp_in.is_same      = mid_ff.is_same;
      if (mid_ff.out_of_range) begin
         rsp_in.month_out = mid_ff.month_orig;
         rsp_in.day_out   = mid_ff.day_orig;
         rsp_in.year_out  = mid_ff.year_orig;
      end else begin
         rsp_in.month_out = mid_ff.month_new;
         rsp_in.day_out   = (mid_ff.day_orig > month_len) ? month_len : mid_ff.day_orig;
         rsp_in.year_out  = mid_ff.year_new;
      end
   end

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start && !busy;
         mid_valid_ff <= in_valid_ff;
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      in_item_ff <= req_item;
      mid_ff     <= mid_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // Every taken item comes out on rsp_strobe after the input, middle and result registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("item taken but no result three cycles later");

   // The comparison gives exactly one answer.
   a_compare_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot({rsp_item.is_before, rsp_item.is_after, rsp_item.is_same}))
      else $error("comparison flags not one-hot");

   // A shifted date always has a real month and a year within range.
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.out_of_range) |->
         (rsp_item.month_out >= 4'd1 && rsp_item.month_out <= 4'd12 &&
          rsp_item.year_out <= dmsc_pkg::YEAR_MAX && rsp_item.day_out <= 5'd31))
      else $error("shifted date out of range without out_of_range");

endmodule

// ===== tb/date_month_shift_and_compare_test.sv =====
// Testbench for date_month_shift_and_compare: directed and random date items.
// Predicts each shifted date and comparison flags in a scoreboard class.
// Depends on dmsc_pkg and the date_month_shift_and_compare top level.
module date_month_shift_and_compare_test;

   // Keeps the predicted results of accepted items, oldest first.
   class date_result_book;
      dmsc_pkg::rsp_type expected_dates[$];
      int                mismatch_count = 0;

      // Works out the shifted date and the flags for one accepted item.
      function void note_item(dmsc_pkg::req_type r);
         dmsc_pkg::rsp_type p;
         int      index;
         int      moved;
         int      new_year;
         int      new_month;
         int      month_len;
         index = int'(r.year_in) * 12 + int'(r.month_in) - 1;
         moved = (r.op == dmsc_pkg::OP_SUB) ? index - int'(r.month_delta)
                                            : index + int'(r.month_delta);
         p = '0;
         p.month_out = r.month_in;
         p.day_out   = r.day_in;
         p.year_out  = r.year_in;
         if (moved < 0 || moved / 12 > int'(dmsc_pkg::YEAR_MAX)) begin
            p.out_of_range = 1'b1;
         end else begin
            new_year  = moved / 12;
            new_month = moved % 12 + 1;
            case (new_month) inside
               2: begin
                  // Leap year: divisible by 4, and not a century unless by 400.
                  if (new_year % 4 == 0 && (new_year % 100 != 0 || new_year % 400 == 0))
                     month_len = 29;
                  else
                     month_len = 28;
               end
               4, 6, 9, 11: month_len = 30;
               default: month_len = 31;
            endcase
            p.month_out = new_month[dmsc_pkg::MONTH_W-1:0];
            p.year_out  = new_year[dmsc_pkg::YEAR_W-1:0];
            p.day_out   = (int'(r.day_in) > month_len) ? month_len[dmsc_pkg::DAY_W-1:0]
                                                       : r.day_in;
         end
         // The raw fields are compared year first, then month, then day.
         if (r.year_in != r.other_year) begin
            p.is_before = r.year_in < r.other_year;
            p.is_after  = r.year_in > r.other_year;
         end else if (r.month_in != r.other_month) begin
            p.is_before = r.month_in < r.other_month;
            p.is_after  = r.month_in > r.other_month;
         end else begin
            p.is_before = r.day_in < r.other_day;
            p.is_after  = r.day_in > r.other_day;
         end
         p.is_same = !p.is_before && !p.is_after;
         expected_dates.push_back(p);
      endfunction

      // Compares one result with the oldest prediction, field by field.
      function void check_item(dmsc_pkg::rsp_type got);
         dmsc_pkg::rsp_type want;
         if (expected_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: m=%0d d=%0d y=%0d", got.month_out,
                        got.day_out, got.year_out);
            return;
         end
         want = expected_dates.pop_front();
         if (got.month_out !== want.month_out || got.day_out !== want.day_out ||
             got.year_out !== want.year_out || got.out_of_range !== want.out_of_range ||
             got.is_before !== want.is_before || got.is_after !== want.is_after ||
             got.is_same !== want.is_same) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch: expected m=%0d d=%0d y=%0d oor=%b lt=%b gt=%b eq=%b",
                        want.month_out, want.day_out, want.year_out, want.out_of_range,
                        want.is_before, want.is_after, want.is_same);
               $display("          got      m=%0d d=%0d y=%0d oor=%b lt=%b gt=%b eq=%b",
                        got.month_out, got.day_out, got.year_out, got.out_of_range,
                        got.is_before, got.is_after, got.is_same);
            end
         end
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction

      // Predictions never answered count as failures too.
      function int failures();
         return mismatch_count + expected_dates.size();
      endfunction
   endclass

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   logic              busy;
   dmsc_pkg::req_type req_item = '0;
   logic              rsp_strobe;
   dmsc_pkg::rsp_type rsp_item;
   date_result_book   book     = new;

   date_month_shift_and_compare u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watch both channels at each rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            book.note_item(req_item);
         if (rsp_strobe)
            book.check_item(rsp_item);
      end
   end

   function automatic dmsc_pkg::req_type date_item(logic op, int m, int d, int y, int delta,
                                                   int om, int od, int oy);
      dmsc_pkg::req_type r;
      r.op          = op;
      r.month_in    = m[dmsc_pkg::MONTH_W-1:0];
      r.day_in      = d[dmsc_pkg::DAY_W-1:0];
      r.year_in     = y[dmsc_pkg::YEAR_W-1:0];
      r.month_delta = delta[dmsc_pkg::DELTA_W-1:0];
      r.other_month = om[dmsc_pkg::MONTH_W-1:0];
      r.other_day   = od[dmsc_pkg::DAY_W-1:0];
      r.other_year  = oy[dmsc_pkg::YEAR_W-1:0];
      return r;
   endfunction

   // Mostly well-formed dates near interesting years, the rest raw bit noise.
   function automatic dmsc_pkg::req_type draw_date_item();
      dmsc_pkg::req_type r;
      int      y;
      if ($urandom_range(0, 9) >= 7) begin
         r = date_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
         return r;
      end
      case ($urandom_range(0, 3))
         0: y = $urandom_range(0, 400);
         1: y = $urandom_range(9600, 9999);
         default: y = $urandom_range(0, 9999);
      endcase
      r = date_item(1'($urandom_range(0, 1)), $urandom_range(1, 12), $urandom_range(1, 31), y,
                    ($urandom_range(0, 9) < 6) ? $urandom_range(0, 60) : $urandom_range(0, 4095),
                    $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 9999));
      // Pick the other date so that every level of the comparison is reached.
      case ($urandom_range(0, 3))
         0: begin
            r.other_month = r.month_in;
            r.other_day   = r.day_in;
            r.other_year  = r.year_in;
         end
         1: begin
            r.other_month = r.month_in;
            r.other_day   = r.day_in;
            r.other_year  = r.year_in;
            case ($urandom_range(0, 2))
               0: r.other_year  = $urandom_range(0, 1) ? r.year_in + 14'd1
                                                       : r.year_in - 14'd1;
               1: r.other_month = $urandom_range(0, 1) ? r.month_in + 4'd1
                                                       : r.month_in - 4'd1;
               default: r.other_day = $urandom_range(0, 1) ? r.day_in + 5'd1
                                                           : r.day_in - 5'd1;
            endcase
         end
         2: r.other_year = r.year_in;
         default: ;
      endcase
      return r;
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic issue_date(input dmsc_pkg::req_type r);
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop sending until every predicted result has come back.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   initial begin
      dmsc_pkg::req_type directed[$];
      int      stretch;
      int      roll;
      stretch = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Month-end clamping, leap rules, year limits, odd fields, every comparison level.
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 1, 31, 2024, 0, 1, 31, 2024));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 1, 31, 2024, 1, 2, 1, 2024));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 1, 31, 2023, 1, 12, 31, 2022));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 1, 30, 1900, 1, 1, 31, 1900));
      directed.push_back(date_item(dmsc_pkg::OP_SUB, 3, 31, 2000, 1, 3, 30, 2000));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 5, 31, 2023, 1, 4, 31, 2023));
      directed.push_back(date_item(dmsc_pkg::OP_SUB, 1, 1, 0, 1, 1, 1, 1));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 12, 31, 9999, 1, 12, 31, 9999));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 12, 31, 9999, 0, 1, 1, 0));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 1, 31, 0, 1, 15, 31, 16383));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 1, 1, 0, 4095, 0, 0, 0));
      directed.push_back(date_item(dmsc_pkg::OP_SUB, 12, 31, 9999, 4095, 12, 31, 9999));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 0, 15, 2020, 0, 1, 15, 2020));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 13, 31, 2020, 0, 12, 31, 2020));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 14, 31, 2020, 0, 14, 30, 2020));
      directed.push_back(date_item(dmsc_pkg::OP_SUB, 15, 31, 2020, 0, 15, 31, 2020));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 2, 0, 2020, 0, 2, 1, 2020));
      directed.push_back(date_item(dmsc_pkg::OP_SUB, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 15, 31, 16383, 0, 15, 31, 16383));
      directed.push_back(date_item(dmsc_pkg::OP_SUB, 15, 31, 16383, 4095, 0, 0, 0));
      directed.push_back(date_item(dmsc_pkg::OP_SUB, 1, 31, 10000, 1, 1, 31, 9999));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 8, 31, 2099, 6, 8, 31, 2100));
      directed.push_back(date_item(dmsc_pkg::OP_ADD, 11, 30, 2399, 3, 11, 29, 2399));
      foreach (directed[i])
         issue_date(directed[i]);
      drain_results();

      // Random items with gaps, unbroken stretches and one mid-run drain.
      for (int n = 0; n < 1530; n++) begin
         if (n == 700)
            drain_results();
         if (stretch > 0) begin
            stretch--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
               stretch = $urandom_range(20, 60);
            else if (roll < 60)
               ;
            else if (roll < 90)
               hold_off($urandom_range(1, 3));
            else
               hold_off($urandom_range(8, 40));
         end
         issue_date(draw_date_item());
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (book.failures() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #1000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== date_month_shift_and_compare.f =====
rtl/core/dmsc_pkg.sv
rtl/core/date_month_shift_and_compare.sv
tb/date_month_shift_and_compare_test.sv
